// ===== rtl/pfh_pkg.sv =====
// ----------------------------------------------------------------------------
// pfh_pkg
// Shared constants, types and the arctangent table of the path follower.
// ----------------------------------------------------------------------------
package pfh_pkg;

    localparam int PATH_DEPTH        = 256;
    localparam int LOOKAHEAD_STEPS   = 3;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int ADDR_W = $clog2(PATH_DEPTH);
    localparam int LEN_W  = $clog2(PATH_DEPTH + 1);
    localparam int ITER_W = $clog2(CORDIC_ITERATIONS);

    // angles in q16 radians
    localparam int ANG_W = 20;
    localparam logic signed [ANG_W-1:0] Q16_PI      = ANG_W'(205887);
    localparam logic signed [ANG_W-1:0] Q16_HALF_PI = ANG_W'(102944);
    localparam logic signed [ANG_W+2:0] Q16_TWO_PI  = (ANG_W+3)'(411775);

    // vector width seen by the cordic, and its internal width
    localparam int VEC_W = 22;
    localparam int CRD_W = 48;

    // config register indexes
    localparam logic REG_CELL_SIZE = 1'b0;
    localparam logic REG_LOST_SQ   = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CALC,
        S_SCAN_SQX,
        S_SCAN_SQY,
        S_GOAL_SEL,
        S_GOAL_RD,
        S_GOAL_CALC,
        S_CORDIC,
        S_WRAP,
        S_OUT
    } state_t;

    typedef enum logic {
        C_IDLE,
        C_RUN
    } cstate_t;

    // round(atan(2^-i) * 65536)
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0:    r = ANG_W'(51472);
            5'd1:    r = ANG_W'(30386);
            5'd2:    r = ANG_W'(16055);
            5'd3:    r = ANG_W'(8150);
            5'd4:    r = ANG_W'(4091);
            5'd5:    r = ANG_W'(2047);
            5'd6:    r = ANG_W'(1024);
            5'd7:    r = ANG_W'(512);
            5'd8:    r = ANG_W'(256);
            5'd9:    r = ANG_W'(128);
            5'd10:   r = ANG_W'(64);
            5'd11:   r = ANG_W'(32);
            5'd12:   r = ANG_W'(16);
            5'd13:   r = ANG_W'(8);
            5'd14:   r = ANG_W'(4);
            5'd15:   r = ANG_W'(2);
            5'd16:   r = ANG_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/pfh_cordic.sv =====
// ----------------------------------------------------------------------------
// pfh_cordic
// Iterative vectoring cordic: atan2(vec_y, vec_x) in q16 radians.
// ----------------------------------------------------------------------------
module pfh_cordic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [pfh_pkg::VEC_W-1:0]      vec_x,
    input  logic signed [pfh_pkg::VEC_W-1:0]      vec_y,
    output logic                                  done,
    output logic signed [pfh_pkg::ANG_W-1:0]      theta
);
    import pfh_pkg::*;

    cstate_t                  cst_reg, cst_next;
    logic [ITER_W-1:0]        it_reg;
    logic signed [CRD_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic                     done_reg;
    logic signed [CRD_W-1:0]  xs, ys, xw, yw;

    // shared shifter, one iteration per cycle
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign xw = CRD_W'(vec_x) <<< 24;
    assign yw = CRD_W'(vec_y) <<< 24;

    always_comb
    begin
        cst_next = cst_reg;
        unique case (cst_reg)
            C_IDLE:
            begin
                if (start && !(vec_x == '0 && vec_y == '0))
                    cst_next = C_RUN;
            end
            C_RUN:
            begin
                if (it_reg == ITER_W'(CORDIC_ITERATIONS - 1))
                    cst_next = C_IDLE;
            end
            default: cst_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg  <= C_IDLE;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            cst_reg  <= cst_next;
            done_reg <= 1'b0;
            if (cst_reg == C_IDLE)
            begin
                it_reg <= '0;
                if (start && vec_x == '0 && vec_y == '0)
                    done_reg <= 1'b1;
            end
            else
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == ITER_W'(CORDIC_ITERATIONS - 1))
                    done_reg <= 1'b1;
            end
        end
    end

    // datapath: pre-rotation into the right half plane, then micro-rotations
    always_ff @(posedge clk)
    begin
        if (cst_reg == C_IDLE)
        begin
            if (start)
            begin
                if (vec_x == '0 && vec_y == '0)
                begin
                    z_reg <= '0;
                end
                else if (vec_x < 0 && vec_y >= 0)
                begin
                    x_reg <= yw;
                    y_reg <= -xw;
                    z_reg <= Q16_HALF_PI;
                end
                else if (vec_x < 0)
                begin
                    x_reg <= -yw;
                    y_reg <= xw;
                    z_reg <= -Q16_HALF_PI;
                end
                else
                begin
                    x_reg <= xw;
                    y_reg <= yw;
                    z_reg <= '0;
                end
            end
        end
        else if (y_reg >= 0)
        begin
            x_reg <= x_reg + ys;
            y_reg <= y_reg - xs;
            z_reg <= z_reg + atan_q16(5'(it_reg));
        end
        else
        begin
            x_reg <= x_reg - ys;
            y_reg <= y_reg + xs;
            z_reg <= z_reg - atan_q16(5'(it_reg));
        end
    end

    assign done  = done_reg;
    assign theta = z_reg;

endmodule

// ===== rtl/path_follow_heading_top.sv =====
// ----------------------------------------------------------------------------
// path_follow_heading_top
// Nearest-waypoint lookahead path follower with cordic heading error.
// ----------------------------------------------------------------------------
// Usage: an item transfers at a rising edge with start high and busy low.
// op = load writes waypoint wp_index, gives no result and
// leaves busy low. op = query scans the loaded path and returns one result
// on goal_x_cm, goal_y_cm, heading_error, lost and no_path, marked by done
// for exactly one cycle; the receiver cannot stall it.
// Query steps: per loaded waypoint a memory read, centre and offset, and two
// passes through the shared squaring multiplier; then goal selection, goal
// read and goal vector, the iterative cordic (no micro-rotations for a zero
// vector), and wrap and output.
// An empty path answers in the cycle right after the transfer.
// busy is high for the whole query; one query is in work at a time.
// Reset clears the path length (empty path), sets cell_size_cm to 10 and
// lost_distance_sq to 2500; the waypoint memory is not cleared.
// Registers sit on an apb port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module path_follow_heading_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [7:0]         wp_index,
    input  logic [7:0]         wp_row,
    input  logic [7:0]         wp_col,
    input  logic               wp_last,
    input  logic [19:0]        pose_x,
    input  logic [19:0]        pose_y,
    input  logic signed [15:0] pose_heading,
    output logic               done,
    output logic [15:0]        goal_x_cm,
    output logic [15:0]        goal_y_cm,
    output logic signed [15:0] heading_error,
    output logic               lost,
    output logic               no_path,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pfh_pkg::*;

    state_t                     state_reg, state_next;
    logic [7:0]                 cell_reg;
    logic [23:0]                thr_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           idx_reg;
    logic [ADDR_W-1:0]          nearest_reg, goal_reg;
    logic [15:0]                mem [PATH_DEPTH];
    logic [15:0]                rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [19:0]                px_reg, py_reg;
    logic signed [15:0]         hd_reg;
    logic signed [VEC_W-1:0]    dx_reg, dy_reg;
    logic [41:0]                sq_reg, best_reg;
    logic signed [VEC_W-1:0]    vx, vy;
    logic [15:0]                gx_reg, gy_reg;
    logic                       lost_reg, nopath_reg;
    logic signed [15:0]         herr_reg;
    logic signed [ANG_W-1:0]    theta;
    logic                       cordic_start, cordic_done;
    logic                       accept, load_wr, cfg_wr;
    logic signed [VEC_W-1:0]    mul_a;
    logic signed [2*VEC_W-1:0]  prod;
    logic [41:0]                dist_sum;
    logic [15:0]                c_col, c_row;
    logic [20:0]                cx, cy;
    logic [15:0]                gx, gy;
    logic [LEN_W:0]             goal_sum;
    logic [LEN_W-1:0]           last_idx;
    logic signed [ANG_W+2:0]    e0, e1;
    logic signed [ANG_W+2:0]    e_rnd;

    assign accept  = start && !busy;
    assign load_wr = accept && op == OP_LOAD;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign busy    = state_reg != S_IDLE;
    assign done    = state_reg == S_OUT;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= 8'd10;
            thr_reg  <= 24'd2500;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CELL_SIZE: cell_reg <= pwdata[7:0];
                REG_LOST_SQ:   thr_reg  <= pwdata[23:0];
                default:       cell_reg <= cell_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_LOST_SQ) ? {8'b0, thr_reg} : {24'b0, cell_reg};

    // path length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (load_wr && wp_last)
            len_reg <= LEN_W'(wp_index) + 1'b1;
    end

    // waypoint memory, row in the upper byte
    assign rd_addr = (state_reg == S_GOAL_RD) ? goal_reg : idx_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (load_wr)
            mem[ADDR_W'(wp_index)] <= {wp_row, wp_col};
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_QUERY)
                    state_next = (len_reg == '0) ? S_OUT : S_SCAN_RD;
            end
            S_SCAN_RD:   state_next = S_SCAN_CALC;
            S_SCAN_CALC: state_next = S_SCAN_SQX;
            S_SCAN_SQX:  state_next = S_SCAN_SQY;
            S_SCAN_SQY:  state_next = (idx_reg == last_idx) ? S_GOAL_SEL : S_SCAN_RD;
            S_GOAL_SEL:  state_next = S_GOAL_RD;
            S_GOAL_RD:   state_next = S_GOAL_CALC;
            S_GOAL_CALC:
            begin
                cordic_start = 1'b1;
                state_next   = S_CORDIC;
            end
            S_CORDIC:    state_next = cordic_done ? S_WRAP : S_CORDIC;
            S_WRAP:      state_next = S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // cell centres in 1/16 cm, goal centres in cm
    assign c_col = rd_data_reg[7:0] * cell_reg;
    assign c_row = rd_data_reg[15:8] * cell_reg;
    assign cx    = {1'b0, c_col, 4'b0} + {10'b0, cell_reg, 3'b0};
    assign cy    = {1'b0, c_row, 4'b0} + {10'b0, cell_reg, 3'b0};
    assign gx    = c_col + {9'b0, cell_reg[7:1]};
    assign gy    = c_row + {9'b0, cell_reg[7:1]};

    // goal vector in 1/16 cm, taken by the cordic when it starts
    assign vx = VEC_W'({gx, 4'b0}) - VEC_W'({2'b0, px_reg});
    assign vy = VEC_W'({gy, 4'b0}) - VEC_W'({2'b0, py_reg});

    // shared squaring multiplier
    assign mul_a    = (state_reg == S_SCAN_SQX) ? dx_reg : dy_reg;
    assign prod     = mul_a * mul_a;
    assign dist_sum = sq_reg + prod[41:0];

    assign last_idx = len_reg - 1'b1;
    assign goal_sum = (LEN_W+1)'(nearest_reg) + (LEN_W+1)'(LOOKAHEAD_STEPS);

    // heading error with one wrap step and rounding to q3.13
    assign e0    = ((ANG_W+3)'(hd_reg) <<< 3) - (ANG_W+3)'(Q16_HALF_PI)
                   + (ANG_W+3)'(theta);
    assign e1    = (e0 > (ANG_W+3)'(Q16_PI))  ? e0 - Q16_TWO_PI :
                   (e0 < -(ANG_W+3)'(Q16_PI)) ? e0 + Q16_TWO_PI : e0;
    assign e_rnd = (e1 + (ANG_W+3)'(4)) >>> 3;

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                idx_reg    <= '0;
                px_reg     <= pose_x;
                py_reg     <= pose_y;
                hd_reg     <= pose_heading;
                nopath_reg <= 1'b1;
                gx_reg     <= '0;
                gy_reg     <= '0;
                herr_reg   <= '0;
                lost_reg   <= 1'b0;
            end
            S_SCAN_CALC:
            begin
                dx_reg <= VEC_W'({2'b0, px_reg}) - VEC_W'({1'b0, cx});
                dy_reg <= VEC_W'({2'b0, py_reg}) - VEC_W'({1'b0, cy});
            end
            S_SCAN_SQX: sq_reg <= prod[41:0];
            S_SCAN_SQY:
            begin
                if (idx_reg == '0 || dist_sum < best_reg)
                begin
                    best_reg    <= dist_sum;
                    nearest_reg <= idx_reg[ADDR_W-1:0];
                end
                idx_reg <= idx_reg + 1'b1;
            end
            S_GOAL_SEL:
            begin
                lost_reg <= best_reg > {10'b0, thr_reg, 8'b0};
                if (goal_sum > (LEN_W+1)'(last_idx))
                    goal_reg <= last_idx[ADDR_W-1:0];
                else
                    goal_reg <= goal_sum[ADDR_W-1:0];
            end
            S_GOAL_CALC:
            begin
                gx_reg <= gx;
                gy_reg <= gy;
            end
            S_WRAP:
            begin
                herr_reg   <= e_rnd[15:0];
                nopath_reg <= 1'b0;
            end
            default: idx_reg <= idx_reg;
        endcase
    end

    pfh_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .vec_x (vx),
        .vec_y (vy),
        .done  (cordic_done),
        .theta (theta)
    );

    assign goal_x_cm     = gx_reg;
    assign goal_y_cm     = gy_reg;
    assign heading_error = herr_reg;
    assign lost          = lost_reg;
    assign no_path       = nopath_reg;

endmodule

// ===== rtl/pfh_checker.sv =====
// ----------------------------------------------------------------------------
// pfh_checker
// Port-level checks of the path follower, bound to the top level.
// ----------------------------------------------------------------------------
module pfh_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               op,
    input logic               done,
    input logic [15:0]        goal_x_cm,
    input logic [15:0]        goal_y_cm,
    input logic signed [15:0] heading_error,
    input logic               lost,
    input logic               no_path
);
    import pfh_pkg::*;

    // a result appears only while a query is in work
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result without query in work");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // an accepted query makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_QUERY) |=> busy)
        else $error("query transfer did not start work");

    // an empty path reports zero fields
    a_nopath_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_path) |-> (goal_x_cm == '0 && goal_y_cm == '0
                               && heading_error == '0 && !lost))
        else $error("no_path result with nonzero fields");

endmodule

bind path_follow_heading_top pfh_checker u_pfh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .goal_x_cm     (goal_x_cm),
    .goal_y_cm     (goal_y_cm),
    .heading_error (heading_error),
    .lost          (lost),
    .no_path       (no_path)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for path_follow_heading_top: loads grid paths, sends
// pose queries and checks goal centre, heading error and flags against an
// in-bench path follower with its own cordic, over several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import pfh_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint ANG_PI      = 205887;
    localparam longint ANG_HALF_PI = 102944;
    localparam longint ANG_TWO_PI  = 411775;

    typedef struct {
        logic [15:0]        gx;
        logic [15:0]        gy;
        logic signed [15:0] herr;
        logic               lost;
        logic               nopath;
    } heading_res_t;

    typedef struct {
        logic               op;
        logic [7:0]         idx;
        logic [7:0]         row;
        logic [7:0]         col;
        logic               last;
        logic [19:0]        px;
        logic [19:0]        py;
        logic signed [15:0] hd;
        bit                 typed;
        heading_res_t       res;
    } path_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               op = 1'b0;
    logic [7:0]         wp_index = '0;
    logic [7:0]         wp_row = '0;
    logic [7:0]         wp_col = '0;
    logic               wp_last = 1'b0;
    logic [19:0]        pose_x = '0;
    logic [19:0]        pose_y = '0;
    logic signed [15:0] pose_heading = '0;
    logic               done;
    logic [15:0]        goal_x_cm;
    logic [15:0]        goal_y_cm;
    logic signed [15:0] heading_error;
    logic               lost;
    logic               no_path;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // bench copy of the block state
    logic [7:0]   wp_rows [256];
    logic [7:0]   wp_cols [256];
    int unsigned  plen;
    int unsigned  cell_cm;
    int unsigned  lost_sq;

    heading_res_t goal_q[$];
    int           mismatches;
    int           items_sent;
    int           idle_pct;
    longint       cycles;
    longint       atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};

    path_follow_heading_top i_dut (.*);

    always #5 clk = ~clk;

    // atan2 in q16 radians, vectoring cordic with floor shifts
    function automatic longint vec_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = ANG_HALF_PI;
            end
            else
            begin
                t = x; x = -y; y = t; z = -ANG_HALF_PI;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z += atan_tab[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    // nearest waypoint, lookahead goal and wrapped heading error
    function automatic heading_res_t follow_path(path_cmd_t c);
        heading_res_t r;
        longint best;
        longint d;
        longint cx;
        longint cy;
        longint gx;
        longint gy;
        longint e;
        int unsigned nearest;
        int unsigned goal;
        r = '{default: '0};
        if (plen == 0)
        begin
            r.nopath = 1'b1;
            return r;
        end
        best = 0;
        nearest = 0;
        for (int unsigned i = 0; i < plen; i++)
        begin
            cx = longint'(wp_cols[i]) * cell_cm * 16 + longint'(cell_cm) * 8;
            cy = longint'(wp_rows[i]) * cell_cm * 16 + longint'(cell_cm) * 8;
            d = (longint'(c.px) - cx) ** 2 + (longint'(c.py) - cy) ** 2;
            if (i == 0 || d < best)
            begin
                best = d;
                nearest = i;
            end
        end
        r.lost = best > longint'(lost_sq) * 256;
        goal = nearest + LOOKAHEAD_STEPS;
        if (goal > plen - 1)
            goal = plen - 1;
        gx = longint'(wp_cols[goal]) * cell_cm + cell_cm / 2;
        gy = longint'(wp_rows[goal]) * cell_cm + cell_cm / 2;
        e = longint'(c.hd) * 8
            - (ANG_HALF_PI - vec_angle(gy * 16 - c.py, gx * 16 - c.px));
        while (e > ANG_PI)
            e -= ANG_TWO_PI;
        while (e < -ANG_PI)
            e += ANG_TWO_PI;
        e = (e + 4) >>> 3;
        r.gx = gx[15:0];
        r.gy = gy[15:0];
        r.herr = e[15:0];
        return r;
    endfunction

    // apb register write, setup then access
    task automatic reg_write(logic ridx, int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {ridx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (ridx == REG_CELL_SIZE)
            cell_cm = value & 8'hFF;
        else
            lost_sq = value & 24'hFFFFFF;
    endtask

    // drive one command, wait for its transfer, then update state
    task automatic send_cmd(path_cmd_t c);
        heading_res_t r;
        op <= c.op;
        wp_index <= c.idx;
        wp_row <= c.row;
        wp_col <= c.col;
        wp_last <= c.last;
        pose_x <= c.px;
        pose_y <= c.py;
        pose_heading <= c.hd;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (c.op == OP_LOAD)
        begin
            wp_rows[c.idx] = c.row;
            wp_cols[c.idx] = c.col;
            if (c.last)
                plen = c.idx + 1;
        end
        else
        begin
            r = follow_path(c);
            goal_q.push_back(c.typed ? c.res : r);
        end
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (goal_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic path_cmd_t mk_cmd(logic o, int idx, int row, int col, logic last,
                                         int px, int py, int hd);
        path_cmd_t c;
        c = '{default: '0};
        c.op = o; c.idx = 8'(idx); c.row = 8'(row); c.col = 8'(col); c.last = last;
        c.px = 20'(px); c.py = 20'(py); c.hd = 16'(hd);
        return c;
    endfunction

    function automatic logic [7:0] rnd_coord();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one waypoint path of n entries followed by one to six queries, most near it
    task automatic run_path(int n);
        path_cmd_t c;
        int k;
        int off;
        longint p;
        for (int i = 0; i < n; i++)
            send_cmd(mk_cmd(OP_LOAD, i, rnd_coord(), rnd_coord(), i == n - 1,
                            $urandom, $urandom, $urandom));
        for (int q = $urandom_range(1, 6); q > 0; q--)
        begin
            c = mk_cmd(OP_QUERY, $urandom, $urandom, $urandom, 1'($urandom),
                       $urandom, $urandom, $urandom);
            if ($urandom_range(3) != 0)
            begin
                k = $urandom_range(n - 1);
                off = $urandom_range(800);
                p = longint'(wp_cols[k]) * cell_cm * 16 + cell_cm * 8 + off - 400;
                c.px = (p < 0) ? 20'd0 : (p > 1048575) ? 20'hFFFFF : p[19:0];
                off = $urandom_range(800);
                p = longint'(wp_rows[k]) * cell_cm * 16 + cell_cm * 8 + off - 400;
                c.py = (p < 0) ? 20'd0 : (p > 1048575) ? 20'hFFFFF : p[19:0];
            end
            send_cmd(c);
        end
        // stray loads that do not end a path
        if ($urandom_range(3) == 0)
            send_cmd(mk_cmd(OP_LOAD, $urandom, $urandom, $urandom, 1'b0,
                            $urandom, $urandom, $urandom));
    endtask

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        heading_res_t x;
        if (rst_n && done)
        begin
            if (goal_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at cycle %0d", cycles);
            end
            else
            begin
                x = goal_q.pop_front();
                if (goal_x_cm !== x.gx || goal_y_cm !== x.gy || heading_error !== x.herr
                    || lost !== x.lost || no_path !== x.nopath)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d: exp gx=%0d gy=%0d he=%0d lost=%0b np=%0b, got gx=%0d gy=%0d he=%0d lost=%0b np=%0b",
                                 cycles, x.gx, x.gy, x.herr, x.lost, x.nopath,
                                 goal_x_cm, goal_y_cm, heading_error, lost, no_path);
                end
            end
        end
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        path_cmd_t dir_tab[$];
        path_cmd_t c;
        int cell_set [4] = '{1, 255, 10, 37};
        int lost_set [4] = '{0, 16777215, 2500, 40000};
        int pct_set [4] = '{0, 71, 0, 33};
        mismatches = 0;
        items_sent = 0;
        idle_pct = 0;
        cycles = 0;
        plen = 0;
        cell_cm = 10;
        lost_sq = 2500;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty path, centre hit, extremes, ties
        c = mk_cmd(OP_QUERY, 0, 0, 0, 0, 1000, 2000, 100);
        c.typed = 1;
        c.res = '{gx: 0, gy: 0, herr: 0, lost: 0, nopath: 1};
        dir_tab.push_back(c);
        dir_tab.push_back(mk_cmd(OP_LOAD, 0, 0, 0, 1, 0, 0, 0));
        // pose on the only centre: zero vector, heading error is -pi/2
        c = mk_cmd(OP_QUERY, 0, 0, 0, 0, 80, 80, 0);
        c.typed = 1;
        c.res = '{gx: 5, gy: 5, herr: -12868, lost: 0, nopath: 0};
        dir_tab.push_back(c);
        dir_tab.push_back(mk_cmd(OP_LOAD, 1, 255, 255, 0, 0, 0, 0));
        dir_tab.push_back(mk_cmd(OP_LOAD, 2, 0, 255, 0, 0, 0, 0));
        dir_tab.push_back(mk_cmd(OP_LOAD, 3, 255, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_cmd(OP_LOAD, 4, 7, 3, 1, 0, 0, 0));
        dir_tab.push_back(mk_cmd(OP_QUERY, 255, 255, 255, 1, 20'hFFFFF, 20'hFFFFF, 25736));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 0, 0, -25736));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 80, 20'hFFFFF, 16'sh7FFF));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 20'hFFFFF, 80, -16'sh8000));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 40880, 40880, 0));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 560, 1200, 12868));
        // tie with entry 0 at the same cell: the first one wins
        dir_tab.push_back(mk_cmd(OP_LOAD, 5, 0, 0, 1, 0, 0, 0));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 80, 80, 0));
        dir_tab.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 90, 70, -1));
        foreach (dir_tab[i])
            send_cmd(dir_tab[i]);
        drain();

        // random phases over register settings and idle patterns
        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(REG_CELL_SIZE, cell_set[ph]);
            reg_write(REG_LOST_SQ, lost_set[ph]);
            idle_pct = pct_set[ph];
            if (ph == 1)
                run_path(256);
            while (items_sent < 40 + 150 * (ph + 1))
                run_path(($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12));
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
